FILE: sv/pmst_pkg.sv
// Shared constants, types and result record for the dense-matrix spanning tree core.
// No dependencies; every other file of the block except pmst_ram imports this package.
package pmst_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int WEIGHT_BITS  = 16;

  // Port field widths (fixed by the external interface)
  localparam int PORT_VIDX_W   = 6;
  localparam int PORT_WEIGHT_W = 16;
  localparam int TOTAL_W       = 22;
  localparam int CFG_W         = 7;

  // Request modes on the input channel
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  // Internal widths derived from the sizing constants
  localparam int VIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W  = VIDX_W + 1;
  localparam int ADJ_AW = 2 * VIDX_W;
  localparam int KEY_W  = WEIGHT_BITS + 1;

  typedef logic [VIDX_W-1:0]      vidx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [ADJ_AW-1:0]      adj_addr_t;
  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic [KEY_W-1:0]       key_t;
  typedef logic [TOTAL_W-1:0]     total_t;

  localparam key_t   KEY_INF   = key_t'(1) << WEIGHT_BITS;
  localparam total_t TOTAL_MAX = '1;

  // Per-vertex scratch word kept in the vertex memory
  typedef struct packed {
    vidx_t parent;
    key_t  key;
  } vtx_t;

  localparam int VTX_W = $bits(vtx_t);

  // One tree-edge result handed from the engine to the output register
  typedef struct packed {
    vidx_t   child;
    vidx_t   parent;
    weight_t edge_weight;
    total_t  total_cost;
    logic    reachable;
    logic    last;
  } res_t;

endpackage

FILE: sv/pmst_if.sv
// Valid/ready channel interfaces for the request, result and configuration ports.
// Depends on pmst_pkg for the field widths.
interface pmst_in_if;
  import pmst_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [PORT_VIDX_W-1:0] row;
  logic [PORT_VIDX_W-1:0] col;
  logic [PORT_WEIGHT_W-1:0] weight;

  modport source (output valid, mode, row, col, weight, input ready);
  modport sink   (input valid, mode, row, col, weight, output ready);
endinterface

interface pmst_out_if;
  import pmst_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [PORT_VIDX_W-1:0]   child;
  logic [PORT_VIDX_W-1:0]   parent;
  logic [PORT_WEIGHT_W-1:0] edge_weight;
  logic [TOTAL_W-1:0]       total_cost;
  logic                     reachable;
  logic                     last;

  modport source (output valid, child, parent, edge_weight, total_cost, reachable, last,
                  input ready);
  modport sink   (input valid, child, parent, edge_weight, total_cost, reachable, last,
                  output ready);
endinterface

interface pmst_cfg_if;
  import pmst_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] vertex_count;

  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

FILE: sv/pmst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module pmst_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/pmst_engine.sv
// Prim sequencer: relaxation/selection passes over the matrix and vertex memories,
// then the per-vertex result walk. Depends on pmst_pkg and the two RAMs in the top level.
module pmst_engine (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [pmst_pkg::CFG_W-1:0] vertex_count,
  output logic                    busy,
  output logic                    adj_re,
  output pmst_pkg::adj_addr_t     adj_raddr,
  input  pmst_pkg::weight_t       adj_rdata,
  output logic                    vtx_re,
  output pmst_pkg::vidx_t         vtx_raddr,
  input  pmst_pkg::vtx_t          vtx_rdata,
  output logic                    vtx_we,
  output pmst_pkg::vidx_t         vtx_waddr,
  output pmst_pkg::vtx_t          vtx_wdata,
  output logic                    res_valid,
  input  logic                    res_ready,
  output pmst_pkg::res_t          res
);
  import pmst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_OUT_RDV, ST_OUT_RDA, ST_OUT_WT, ST_EMIT
  } state_t;

  state_t                  state_r, state_nxt;
  cnt_t                    n_r, n_nxt;
  cnt_t                    v_r, v_nxt;
  vidx_t                   u_r, u_nxt;
  vidx_t                   d_v_r, d_v_nxt;
  logic                    d_valid_r, d_valid_nxt;
  logic                    first_r, first_nxt;
  logic [MAX_VERTICES-1:0] in_tree_r, in_tree_nxt;
  key_t                    least_r, least_nxt;
  vidx_t                   best_r, best_nxt;
  logic                    found_r, found_nxt;
  vidx_t                   p_r, p_nxt;
  total_t                  total_r, total_nxt;
  res_t                    res_r, res_nxt;

  cnt_t                    n_cfg;
  key_t                    old_key;
  vidx_t                   old_parent;
  logic                    relax;
  key_t                    new_key;
  vidx_t                   new_parent;
  logic [TOTAL_W:0]        sum;

  // Clamp the vertex count to the matrix size
  always_comb begin
    if (int'(vertex_count) > MAX_VERTICES) begin
      n_cfg = cnt_t'(MAX_VERTICES);
    end else begin
      n_cfg = cnt_t'(vertex_count);
    end
  end

  // Relaxation of the vertex whose data arrives this cycle; the first pass
  // sees every key as infinite
  always_comb begin
    old_key    = first_r ? KEY_INF : vtx_rdata.key;
    old_parent = first_r ? '0 : vtx_rdata.parent;
    relax      = (adj_rdata != '0) && !in_tree_r[d_v_r] && (key_t'(adj_rdata) < old_key);
    new_key    = relax ? key_t'(adj_rdata) : old_key;
    new_parent = relax ? u_r : old_parent;
    sum        = {1'b0, total_r} + (TOTAL_W+1)'(adj_rdata);
  end

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    v_nxt       = v_r;
    u_nxt       = u_r;
    d_v_nxt     = d_v_r;
    d_valid_nxt = 1'b0;
    first_nxt   = first_r;
    in_tree_nxt = in_tree_r;
    least_nxt   = least_r;
    best_nxt    = best_r;
    found_nxt   = found_r;
    p_nxt       = p_r;
    total_nxt   = total_r;
    res_nxt     = res_r;
    adj_re      = 1'b0;
    adj_raddr   = {u_r, v_r[VIDX_W-1:0]};
    vtx_re      = 1'b0;
    vtx_raddr   = v_r[VIDX_W-1:0];
    vtx_we      = 1'b0;
    vtx_waddr   = d_v_r;
    vtx_wdata   = '{parent: new_parent, key: new_key};

    case (state_r)
      ST_IDLE: begin
        if (start && (n_cfg >= cnt_t'(2))) begin
          n_nxt       = n_cfg;
          u_nxt       = '0;
          v_nxt       = '0;
          first_nxt   = 1'b1;
          in_tree_nxt = MAX_VERTICES'(1);
          least_nxt   = KEY_INF;
          found_nxt   = 1'b0;
          total_nxt   = '0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue the next column of row u
        if (v_r < n_r) begin
          adj_re      = 1'b1;
          vtx_re      = 1'b1;
          d_valid_nxt = 1'b1;
          d_v_nxt     = v_r[VIDX_W-1:0];
          v_nxt       = v_r + cnt_t'(1);
        end
        // write back the relaxed key and track the smallest open key
        if (d_valid_r) begin
          vtx_we = 1'b1;
          if (!in_tree_r[d_v_r] && (new_key < least_r)) begin
            least_nxt = new_key;
            best_nxt  = d_v_r;
            found_nxt = 1'b1;
          end
        end
        if ((v_r == n_r) && !d_valid_r) begin
          if (found_r) begin
            in_tree_nxt[best_r] = 1'b1;
            u_nxt     = best_r;
            v_nxt     = '0;
            first_nxt = 1'b0;
            least_nxt = KEY_INF;
            found_nxt = 1'b0;
          end else begin
            v_nxt     = cnt_t'(1);
            state_nxt = ST_OUT_RDV;
          end
        end
      end
      ST_OUT_RDV: begin
        if (in_tree_r[v_r[VIDX_W-1:0]]) begin
          vtx_re    = 1'b1;
          state_nxt = ST_OUT_RDA;
        end else begin
          res_nxt = '{child: v_r[VIDX_W-1:0], parent: '0, edge_weight: '0,
                      total_cost: total_r, reachable: 1'b0,
                      last: (v_r == n_r - cnt_t'(1))};
          state_nxt = ST_EMIT;
        end
      end
      ST_OUT_RDA: begin
        p_nxt     = vtx_rdata.parent;
        adj_re    = 1'b1;
        adj_raddr = {v_r[VIDX_W-1:0], vtx_rdata.parent};
        state_nxt = ST_OUT_WT;
      end
      ST_OUT_WT: begin
        total_nxt = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        res_nxt   = '{child: v_r[VIDX_W-1:0], parent: p_r, edge_weight: adj_rdata,
                      total_cost: total_nxt, reachable: 1'b1,
                      last: (v_r == n_r - cnt_t'(1))};
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready) begin
          if (v_r == n_r - cnt_t'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            v_nxt     = v_r + cnt_t'(1);
            state_nxt = ST_OUT_RDV;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    n_r       <= n_nxt;
    v_r       <= v_nxt;
    u_r       <= u_nxt;
    d_v_r     <= d_v_nxt;
    d_valid_r <= d_valid_nxt;
    first_r   <= first_nxt;
    in_tree_r <= in_tree_nxt;
    least_r   <= least_nxt;
    best_r    <= best_nxt;
    found_r   <= found_nxt;
    p_r       <= p_nxt;
    total_r   <= total_nxt;
    res_r     <= res_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_EMIT);
  assign res       = res_r;

endmodule

FILE: sv/prim_mst_dense_matrix_core.sv
// Operation: a load writes one matrix entry. A run over n vertices makes up to n passes
//   (one matrix read per column), then walks vertices 1 to n-1, reading the parent and edge
//   weight of each reachable vertex, and hands each result to the output register.
// Throughput: one load per cycle; one run at a time, new requests held off while it runs.
// Reset: rst_n (synchronous, active low) clears the sequencer and output valid and sets
//   vertex_count to 1; matrix contents are undefined until written.
module prim_mst_dense_matrix_core (
  input logic         clk,
  input logic         rst_n,
  pmst_in_if.sink     in_req,
  pmst_out_if.source  out_res,
  pmst_cfg_if.sink    cfg_wr
);
  import pmst_pkg::*;

  logic [CFG_W-1:0] vertex_count_r, vertex_count_nxt;
  logic             busy;
  logic             in_fire;
  logic             load_we;
  logic             run_start;

  logic             adj_re;
  adj_addr_t        adj_raddr;
  weight_t          adj_rdata;
  logic             vtx_re;
  vidx_t            vtx_raddr;
  vtx_t             vtx_rdata;
  logic [VTX_W-1:0] vtx_rdata_raw;
  logic             vtx_we;
  vidx_t            vtx_waddr;
  vtx_t             vtx_wdata;

  logic             res_valid;
  logic             res_ready;
  res_t             res;

  logic             out_valid_r, out_valid_nxt;
  res_t             out_r, out_nxt;

  // Configuration: always ready, only written while idle by contract
  assign cfg_wr.ready = 1'b1;

  always_comb begin
    vertex_count_nxt = vertex_count_r;
    if (cfg_wr.valid) begin
      vertex_count_nxt = cfg_wr.vertex_count;
    end
  end

  // Requests are taken only while no run is in progress
  assign in_req.ready = !busy;
  assign in_fire      = in_req.valid && !busy;
  assign run_start    = in_fire && (in_req.mode == MODE_RUN);
  // Drop writes whose coordinates fall outside the matrix
  assign load_we      = in_fire && (in_req.mode == MODE_LOAD) &&
                        (int'(in_req.row) < MAX_VERTICES) &&
                        (int'(in_req.col) < MAX_VERTICES);

  // Adjacency matrix, row-major: address = {row, col}
  pmst_ram #(
    .DEPTH (MAX_VERTICES * MAX_VERTICES),
    .WIDTH (WEIGHT_BITS)
  ) u_adj_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr ({vidx_t'(in_req.row), vidx_t'(in_req.col)}),
    .wdata (weight_t'(in_req.weight)),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // Per-vertex key and parent scratch
  pmst_ram #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (VTX_W)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (vtx_we),
    .waddr (vtx_waddr),
    .wdata (vtx_wdata),
    .re    (vtx_re),
    .raddr (vtx_raddr),
    .rdata (vtx_rdata_raw)
  );

  assign vtx_rdata = vtx_t'(vtx_rdata_raw);

  pmst_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (run_start),
    .vertex_count (vertex_count_r),
    .busy         (busy),
    .adj_re       (adj_re),
    .adj_raddr    (adj_raddr),
    .adj_rdata    (adj_rdata),
    .vtx_re       (vtx_re),
    .vtx_raddr    (vtx_raddr),
    .vtx_rdata    (vtx_rdata),
    .vtx_we       (vtx_we),
    .vtx_waddr    (vtx_waddr),
    .vtx_wdata    (vtx_wdata),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // Output register: advance when empty or when the sink takes the held result
  assign res_ready = !out_valid_r || out_res.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= CFG_W'(1);
      out_valid_r    <= 1'b0;
    end else begin
      vertex_count_r <= vertex_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.child       = PORT_VIDX_W'(out_r.child);
  assign out_res.parent      = PORT_VIDX_W'(out_r.parent);
  assign out_res.edge_weight = PORT_WEIGHT_W'(out_r.edge_weight);
  assign out_res.total_cost  = out_r.total_cost;
  assign out_res.reachable   = out_r.reachable;
  assign out_res.last        = out_r.last;

endmodule

FILE: sv/pmst_checker.sv
// Port-level checks for prim_mst_dense_matrix_core, attached by the bind at the end.
// Depends on pmst_pkg for field widths.
module pmst_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [pmst_pkg::PORT_VIDX_W-1:0]   out_child,
  input logic [pmst_pkg::PORT_VIDX_W-1:0]   out_parent,
  input logic [pmst_pkg::PORT_WEIGHT_W-1:0] out_edge_weight,
  input logic [pmst_pkg::TOTAL_W-1:0]       out_total_cost,
  input logic                             out_reachable
);
  import pmst_pkg::*;

  // A stalled result holds its valid, child and total cost
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_child) && $stable(out_total_cost))
    else $error("result changed while stalled");

  // Vertex 0 is the root and is never reported
  a_child_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_child != '0)
    else $error("result reports the root vertex");

  // Unreachable vertices carry no parent and no weight
  a_unreach_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reachable |-> out_parent == '0 && out_edge_weight == '0)
    else $error("unreachable result carries an edge");

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind prim_mst_dense_matrix_core pmst_checker u_pmst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_child       (out_res.child),
  .out_parent      (out_res.parent),
  .out_edge_weight (out_res.edge_weight),
  .out_total_cost  (out_res.total_cost),
  .out_reachable   (out_res.reachable)
);
